// ===== src/scg_pkg.sv =====
// ----------------------------------------------------------------------------
// scg_pkg
// Shared types, constants and the 5x7 font table of the glyph cell generator.
// ----------------------------------------------------------------------------
package scg_pkg;

    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;
    localparam int DIGIT_BASE = 27;

    localparam logic [2:0] LAST_COL = 3'(GLYPH_COLS - 1);
    localparam logic [2:0] LAST_ROW = 3'(GLYPH_ROWS - 1);

    localparam logic [7:0] CODE_SPACE   = 8'h20;
    localparam logic [7:0] CODE_UPPER_A = 8'h41;
    localparam logic [7:0] CODE_UPPER_Z = 8'h5A;
    localparam logic [7:0] CODE_LOWER_A = 8'h61;
    localparam logic [7:0] CODE_LOWER_Z = 8'h7A;
    localparam logic [7:0] CODE_DIGIT_0 = 8'h30;
    localparam logic [7:0] CODE_DIGIT_9 = 8'h39;

    typedef logic [5:0] glyph_slot_t;
    typedef logic [2:0] glyph_idx_t;
    typedef logic [7:0] glyph_col_t;

    typedef struct packed {
        logic        hit;
        glyph_slot_t slot;
    } glyph_lookup_t;

    function automatic glyph_lookup_t lookup_glyph(input logic [7:0] code);
        glyph_lookup_t res;
        res.hit  = 1'b1;
        res.slot = '0;
        if (code == CODE_SPACE)
        begin
            res.slot = '0;
        end
        else if (code >= CODE_UPPER_A && code <= CODE_UPPER_Z)
        begin
            res.slot = 6'(code - CODE_UPPER_A + 8'd1);
        end
        else if (code >= CODE_LOWER_A && code <= CODE_LOWER_Z)
        begin
            res.slot = 6'(code - CODE_LOWER_A + 8'd1);
        end
        else if (code >= CODE_DIGIT_0 && code <= CODE_DIGIT_9)
        begin
            res.slot = 6'(code - CODE_DIGIT_0 + 8'(DIGIT_BASE));
        end
        else
        begin
            res.hit = 1'b0;
        end
        return res;
    endfunction

    // column 0 in bits [7:0], column 4 in bits [39:32]
    function automatic logic [39:0] glyph_row(input glyph_slot_t slot);
        logic [39:0] g;
        unique case (slot)
            6'd0:    g = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
            6'd1:    g = {8'h7C, 8'h12, 8'h11, 8'h12, 8'h7C};
            6'd2:    g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h7F};
            6'd3:    g = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
            6'd4:    g = {8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F};
            6'd5:    g = {8'h41, 8'h49, 8'h49, 8'h49, 8'h7F};
            6'd6:    g = {8'h01, 8'h09, 8'h09, 8'h09, 8'h7F};
            6'd7:    g = {8'h7A, 8'h49, 8'h49, 8'h41, 8'h3E};
            6'd8:    g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
            6'd9:    g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
            6'd10:   g = {8'h01, 8'h3F, 8'h41, 8'h40, 8'h20};
            6'd11:   g = {8'h41, 8'h22, 8'h14, 8'h08, 8'h7F};
            6'd12:   g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h7F};
            6'd13:   g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
            6'd14:   g = {8'h7F, 8'h10, 8'h08, 8'h04, 8'h7F};
            6'd15:   g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
            6'd16:   g = {8'h06, 8'h09, 8'h09, 8'h09, 8'h7F};
            6'd17:   g = {8'h5E, 8'h21, 8'h51, 8'h41, 8'h3E};
            6'd18:   g = {8'h46, 8'h29, 8'h19, 8'h09, 8'h7F};
            6'd19:   g = {8'h32, 8'h49, 8'h49, 8'h49, 8'h26};
            6'd20:   g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
            6'd21:   g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
            6'd22:   g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
            6'd23:   g = {8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F};
            6'd24:   g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
            6'd25:   g = {8'h03, 8'h04, 8'h78, 8'h04, 8'h03};
            6'd26:   g = {8'h43, 8'h45, 8'h49, 8'h51, 8'h61};
            6'd27:   g = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
            6'd28:   g = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
            6'd29:   g = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
            6'd30:   g = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
            6'd31:   g = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
            6'd32:   g = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
            6'd33:   g = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
            6'd34:   g = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
            6'd35:   g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
            6'd36:   g = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

// ===== src/scaled_glyph_cell_generator_unit.sv =====
// ----------------------------------------------------------------------------
// scaled_glyph_cell_generator_unit
// Expands one character word into 35 scaled glyph cell words, one per cycle while
// the output is not stalled. Each cell word is registered from the cell sequencer.
// Flow: the cell sequencer steps one dot per cycle while the output is not
//   stalled; the next character is taken with the last cell.
// Unsupported codes are dropped at acceptance with no output.
// Reset: rst_n clears the item and output valid flags; no words are pending.
// ----------------------------------------------------------------------------
module scaled_glyph_cell_generator_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [15:0]            origin_x,
    input  logic [15:0]            origin_y,
    input  logic [7:0]             char_code,
    input  logic [15:0]            fore_color,
    input  logic [15:0]            back_color,
    input  logic [7:0]             pixel_scale,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COORD_WIDTH-1:0] win_left,
    output logic [COORD_WIDTH-1:0] win_top,
    output logic [COORD_WIDTH-1:0] win_right,
    output logic [COORD_WIDTH-1:0] win_bottom,
    output logic [15:0]            cell_color,
    output logic [15:0]            pixel_count,
    output logic                   last_cell
);
    import scg_pkg::*;

    typedef logic [COORD_WIDTH-1:0] coord_t;

    logic          item_valid_reg;
    glyph_slot_t   slot_reg;
    coord_t        oy_reg;
    coord_t        sc_reg;
    logic [15:0]   fg_reg;
    logic [15:0]   bg_reg;
    logic [15:0]   count_reg;
    glyph_idx_t    col_reg;
    glyph_idx_t    row_reg;
    coord_t        left_reg;
    coord_t        top_reg;

    logic          out_valid_reg;
    coord_t        win_left_reg;
    coord_t        win_top_reg;
    coord_t        win_right_reg;
    coord_t        win_bottom_reg;
    logic [15:0]   cell_color_reg;
    logic [15:0]   pixel_count_reg;
    logic          last_cell_reg;

    glyph_lookup_t lookup;
    logic [6:0]    col_bits;
    logic          advance;
    logic          at_last;
    logic          accept;

    assign lookup  = lookup_glyph(char_code);
    assign advance = item_valid_reg && (!out_valid_reg || out_ready);
    assign at_last = (col_reg == LAST_COL) && (row_reg == LAST_ROW);
    assign in_ready = !item_valid_reg || (advance && at_last);
    assign accept  = in_valid && in_ready;

    scg_glyph_rom u_rom (
        .slot     (slot_reg),
        .col      (col_reg),
        .col_bits (col_bits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                item_valid_reg <= lookup.hit;
            end
            else if (advance && at_last)
            begin
                item_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // load a new character or advance column-major through its dots
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg  <= lookup.slot;
            oy_reg    <= COORD_WIDTH'(origin_y);
            sc_reg    <= COORD_WIDTH'(pixel_scale);
            fg_reg    <= fore_color;
            bg_reg    <= back_color;
            count_reg <= 16'(pixel_scale) * 16'(pixel_scale);
            col_reg   <= '0;
            row_reg   <= '0;
            left_reg  <= COORD_WIDTH'(origin_x);
            top_reg   <= COORD_WIDTH'(origin_y);
        end
        else if (advance)
        begin
            if (row_reg == LAST_ROW)
            begin
                row_reg  <= '0;
                col_reg  <= 3'(col_reg + 3'd1);
                left_reg <= coord_t'(left_reg + sc_reg);
                top_reg  <= oy_reg;
            end
            else
            begin
                row_reg <= 3'(row_reg + 3'd1);
                top_reg <= coord_t'(top_reg + sc_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            win_left_reg    <= left_reg;
            win_top_reg     <= top_reg;
            win_right_reg   <= coord_t'(left_reg + sc_reg - coord_t'(1));
            win_bottom_reg  <= coord_t'(top_reg + sc_reg - coord_t'(1));
            cell_color_reg  <= col_bits[row_reg] ? fg_reg : bg_reg;
            pixel_count_reg <= count_reg;
            last_cell_reg   <= at_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign win_left    = win_left_reg;
    assign win_top     = win_top_reg;
    assign win_right   = win_right_reg;
    assign win_bottom  = win_bottom_reg;
    assign cell_color  = cell_color_reg;
    assign pixel_count = pixel_count_reg;
    assign last_cell   = last_cell_reg;

endmodule

// ===== src/scg_glyph_rom.sv =====
// ----------------------------------------------------------------------------
// scg_glyph_rom
// Font table read: one glyph column of seven dots for a slot and a column.
// ----------------------------------------------------------------------------
module scg_glyph_rom (
    input  scg_pkg::glyph_slot_t slot,
    input  scg_pkg::glyph_idx_t  col,
    output logic [6:0]           col_bits
);
    import scg_pkg::*;

    logic [39:0] row_word;
    glyph_col_t  col_byte;

    assign row_word = glyph_row(slot);

    always_comb
    begin
        unique case (col)
            3'd0:    col_byte = row_word[7:0];
            3'd1:    col_byte = row_word[15:8];
            3'd2:    col_byte = row_word[23:16];
            3'd3:    col_byte = row_word[31:24];
            3'd4:    col_byte = row_word[39:32];
            default: col_byte = '0;
        endcase
    end

    assign col_bits = col_byte[6:0];

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for scaled_glyph_cell_generator_unit. Character words
// are queued up front and sent by a valid/ready driver. A local 5x7 font
// predictor turns each accepted character that has a glyph into its 35 cell
// words, and a monitor compares every cell word with the oldest prediction.
// Both sides idle at random, each with one stretch that does not idle.
// ----------------------------------------------------------------------------
module tb;
    import scg_pkg::*;

    localparam int QUIET_CHAR_LO = 40;
    localparam int QUIET_CHAR_HI = 70;
    localparam int QUIET_CELL_LO = 1200;
    localparam int QUIET_CELL_HI = 2400;
    localparam int IDLE_PCT      = 16;
    localparam int RANDOM_CHARS  = 80;
    localparam int DRAIN_CYCLES  = 20;
    localparam int STALL_LIMIT   = 2000;
    localparam int NO_GLYPH      = -1;

    typedef struct {
        logic [15:0] ox;
        logic [15:0] oy;
        logic [7:0]  code;
        logic [15:0] fg;
        logic [15:0] bg;
        logic [7:0]  sc;
    } char_word_t;

    typedef struct {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
        logic [15:0] color;
        logic [15:0] count;
        logic        last;
    } cell_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] origin_x = '0;
    logic [15:0] origin_y = '0;
    logic [7:0]  char_code = '0;
    logic [15:0] fore_color = '0;
    logic [15:0] back_color = '0;
    logic [7:0]  pixel_scale = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] win_left;
    logic [15:0] win_top;
    logic [15:0] win_right;
    logic [15:0] win_bottom;
    logic [15:0] cell_color;
    logic [15:0] pixel_count;
    logic        last_cell;

    char_word_t pending_chars[$];
    cell_word_t expected_cells[$];
    char_word_t held_char;
    char_word_t next_char;
    cell_word_t got_cell;
    cell_word_t want_cell;

    int n_chars_in = 0;
    int n_dropped = 0;
    int n_cells = 0;
    int n_errors = 0;
    int stall_cycles = 0;

    scaled_glyph_cell_generator_unit #(
        .COORD_WIDTH(16)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .origin_x   (origin_x),
        .origin_y   (origin_y),
        .char_code  (char_code),
        .fore_color (fore_color),
        .back_color (back_color),
        .pixel_scale(pixel_scale),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .win_left   (win_left),
        .win_top    (win_top),
        .win_right  (win_right),
        .win_bottom (win_bottom),
        .cell_color (cell_color),
        .pixel_count(pixel_count),
        .last_cell  (last_cell)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int font_slot(input logic [7:0] code);
        if (code == CODE_SPACE)
            return 0;
        if (code >= CODE_UPPER_A && code <= CODE_UPPER_Z)
            return int'(code - CODE_UPPER_A) + 1;
        if (code >= CODE_LOWER_A && code <= CODE_LOWER_Z)
            return int'(code - CODE_LOWER_A) + 1;
        if (code >= CODE_DIGIT_0 && code <= CODE_DIGIT_9)
            return int'(code - CODE_DIGIT_0) + DIGIT_BASE;
        return NO_GLYPH;
    endfunction

    // column 0 in the top byte, column 4 in the bottom byte
    function automatic logic [39:0] font_columns(input int slot);
        case (slot)
            0:  return {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
            1:  return {8'h7C, 8'h12, 8'h11, 8'h12, 8'h7C};
            2:  return {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
            3:  return {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
            4:  return {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
            5:  return {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
            6:  return {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
            7:  return {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
            8:  return {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
            9:  return {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
            10: return {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
            11: return {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
            12: return {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
            13: return {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
            14: return {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
            15: return {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
            16: return {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
            17: return {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
            18: return {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
            19: return {8'h26, 8'h49, 8'h49, 8'h49, 8'h32};
            20: return {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
            21: return {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
            22: return {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
            23: return {8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F};
            24: return {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
            25: return {8'h03, 8'h04, 8'h78, 8'h04, 8'h03};
            26: return {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
            27: return {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
            28: return {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
            29: return {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
            30: return {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
            31: return {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
            32: return {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
            33: return {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
            34: return {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
            35: return {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
            36: return {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
            default: return '0;
        endcase
    endfunction

    task automatic expand_char(input char_word_t w);
        int          slot;
        logic [39:0] cols;
        logic [7:0]  bits;
        cell_word_t  c;
        slot = font_slot(w.code);
        if (slot == NO_GLYPH)
        begin
            n_dropped++;
            return;
        end
        cols = font_columns(slot);
        for (int col = 0; col < GLYPH_COLS; col++)
        begin
            bits = cols[39 - 8 * col -: 8];
            for (int row = 0; row < GLYPH_ROWS; row++)
            begin
                c.left   = 16'(int'(w.ox) + col * int'(w.sc));
                c.top    = 16'(int'(w.oy) + row * int'(w.sc));
                c.right  = 16'(int'(c.left) + int'(w.sc) - 1);
                c.bottom = 16'(int'(c.top) + int'(w.sc) - 1);
                c.color  = bits[row] ? w.fg : w.bg;
                c.count  = 16'(int'(w.sc) * int'(w.sc));
                c.last   = (col == GLYPH_COLS - 1) && (row == GLYPH_ROWS - 1);
                expected_cells.push_back(c);
            end
        end
    endtask

    task automatic queue_char(input logic [15:0] ox, input logic [15:0] oy,
                              input logic [7:0] code, input logic [15:0] fg,
                              input logic [15:0] bg, input logic [7:0] sc);
        char_word_t w;
        w.ox = ox;
        w.oy = oy;
        w.code = code;
        w.fg = fg;
        w.bg = bg;
        w.sc = sc;
        pending_chars.push_back(w);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_errors++;
        end
    endtask

    function automatic logic [7:0] pick_code();
        int r;
        if ($urandom_range(99) >= 80)
            return 8'($urandom_range(255));
        r = $urandom_range(62);
        if (r == 0)
            return CODE_SPACE;
        if (r <= 26)
            return 8'(int'(CODE_UPPER_A) + r - 1);
        if (r <= 52)
            return 8'(int'(CODE_LOWER_A) + r - 27);
        return 8'(int'(CODE_DIGIT_0) + r - 53);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expand_char(held_char);
                n_chars_in++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_chars.size() != 0 &&
                    !(($urandom_range(99) < IDLE_PCT) &&
                      !(n_chars_in >= QUIET_CHAR_LO && n_chars_in < QUIET_CHAR_HI)))
                begin
                    next_char = pending_chars.pop_front();
                    held_char = next_char;
                    origin_x    <= next_char.ox;
                    origin_y    <= next_char.oy;
                    char_code   <= next_char.code;
                    fore_color  <= next_char.fg;
                    back_color  <= next_char.bg;
                    pixel_scale <= next_char.sc;
                    in_valid    <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_cell.left   = win_left;
                got_cell.top    = win_top;
                got_cell.right  = win_right;
                got_cell.bottom = win_bottom;
                got_cell.color  = cell_color;
                got_cell.count  = pixel_count;
                got_cell.last   = last_cell;
                if (expected_cells.size() == 0)
                begin
                    $error("unexpected cell word: left %0h top %0h color %0h",
                           got_cell.left, got_cell.top, got_cell.color);
                    n_errors++;
                end
                else
                begin
                    want_cell = expected_cells.pop_front();
                    check_field("win_left", want_cell.left, got_cell.left);
                    check_field("win_top", want_cell.top, got_cell.top);
                    check_field("win_right", want_cell.right, got_cell.right);
                    check_field("win_bottom", want_cell.bottom, got_cell.bottom);
                    check_field("cell_color", want_cell.color, got_cell.color);
                    check_field("pixel_count", want_cell.count, got_cell.count);
                    check_field("last_cell", 16'(want_cell.last), 16'(got_cell.last));
                end
                n_cells++;
            end
            out_ready <= !(($urandom_range(99) < IDLE_PCT) &&
                           !(n_cells >= QUIET_CELL_LO && n_cells < QUIET_CELL_HI));
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no word accepted for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int supported;
        logic [7:0] code;

        // directed: font edges, unsupported neighbors, scale and wrap extremes
        queue_char(16'h0000, 16'h0000, CODE_SPACE,   16'hFFFF, 16'h0000, 8'd1);
        queue_char(16'h0010, 16'h0020, CODE_UPPER_A, 16'hF800, 16'h07E0, 8'd2);
        queue_char(16'h1234, 16'h4321, CODE_UPPER_Z, 16'h001F, 16'hFFE0, 8'd3);
        queue_char(16'h0100, 16'h0200, CODE_LOWER_A, 16'hAAAA, 16'h5555, 8'd4);
        queue_char(16'h0300, 16'h0400, CODE_LOWER_Z, 16'h5555, 16'hAAAA, 8'd5);
        queue_char(16'h0500, 16'h0600, CODE_DIGIT_0, 16'h0F0F, 16'hF0F0, 8'd6);
        queue_char(16'h0700, 16'h0800, CODE_DIGIT_9, 16'hF0F0, 16'h0F0F, 8'd7);
        queue_char(16'h0000, 16'h0000, 8'h00,        16'hFFFF, 16'hFFFF, 8'd1);
        queue_char(16'h0000, 16'h0000, 8'h1F,        16'hFFFF, 16'hFFFF, 8'd1);
        queue_char(16'h0000, 16'h0000, 8'h21,        16'hFFFF, 16'hFFFF, 8'd1);
        queue_char(16'h0000, 16'h0000, 8'h2F,        16'hFFFF, 16'hFFFF, 8'd1);
        queue_char(16'h0000, 16'h0000, 8'h3A,        16'hFFFF, 16'hFFFF, 8'd1);
        queue_char(16'h0000, 16'h0000, 8'h40,        16'hFFFF, 16'hFFFF, 8'd1);
        queue_char(16'h0000, 16'h0000, 8'h5B,        16'hFFFF, 16'hFFFF, 8'd1);
        queue_char(16'h0000, 16'h0000, 8'h60,        16'hFFFF, 16'hFFFF, 8'd1);
        queue_char(16'h0000, 16'h0000, 8'h7B,        16'hFFFF, 16'hFFFF, 8'd1);
        queue_char(16'h0000, 16'h0000, 8'h80,        16'hFFFF, 16'hFFFF, 8'd1);
        queue_char(16'h0000, 16'h0000, 8'hFF,        16'hFFFF, 16'hFFFF, 8'd1);
        queue_char(16'h8000, 16'h8000, 8'h4D,        16'hFFFF, 16'h0000, 8'd0);
        queue_char(16'h0000, 16'h0000, 8'h57,        16'h1234, 16'h4321, 8'd0);
        queue_char(16'hFFFF, 16'hFFFF, 8'h38,        16'h0000, 16'hFFFF, 8'd255);
        queue_char(16'hFFF0, 16'hFFFA, 8'h6B,        16'hFFFF, 16'h0000, 8'd255);
        queue_char(16'hFFFF, 16'hFFFF, 8'h51,        16'hFFFF, 16'h0000, 8'd1);
        queue_char(16'hFF00, 16'h0000, 8'h34,        16'h8001, 16'h7FFE, 8'd128);

        supported = 0;
        while (supported < RANDOM_CHARS)
        begin
            code = pick_code();
            if (font_slot(code) != NO_GLYPH)
                supported++;
            queue_char(16'($urandom_range(65535)), 16'($urandom_range(65535)), code,
                       16'($urandom_range(65535)), 16'($urandom_range(65535)),
                       ($urandom_range(1) != 0) ? 8'($urandom_range(255))
                                                : 8'($urandom_range(8)));
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_chars.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d characters (%0d without a glyph), %0d cell words checked",
                 n_chars_in, n_dropped, n_cells);
        $display("font edges, zero and full scale, and coordinate wrap were exercised");
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
